// ===== src/sequence_list_engine_top_assert.svh =====
// ---------------------------------------------------------------------------
// sequence list engine assertion macros
// concurrent checks on clk, disabled while rst is high
// ---------------------------------------------------------------------------
`ifndef SEQUENCE_LIST_ENGINE_TOP_ASSERT_SVH
`define SEQUENCE_LIST_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// condition implies check in the same cycle
`define SLE_ASSERT_NOW(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
    else $error(msg);
// condition implies check in the next cycle
`define SLE_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
    else $error(msg);
`else
`define SLE_ASSERT_NOW(label, cond, check, msg)
`define SLE_ASSERT_NEXT(label, cond, check, msg)
`endif

`endif

// ===== src/sle_pkg.sv =====
// ---------------------------------------------------------------------------
// sle_pkg
// shared types and codes for the sequence list engine
// ---------------------------------------------------------------------------
package sle_pkg;

  localparam int SLE_DEPTH      = 16;
  localparam int SLE_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_ERASE_AT   = 3'd5,
    OP_FIND       = 3'd6
  } sle_op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } sle_status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_ERASE,
    CMD_MATCH,
    CMD_SCAN
  } sle_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } sle_state_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [4:0]         position;
    logic signed [31:0] value;
  } sle_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] found_index;
    logic [4:0] count;
  } sle_rsp_t;

endpackage

// ===== src/sle_cell.sv =====
// ---------------------------------------------------------------------------
// sle_cell
// one list slot: holds an entry and a match bit, trades with its neighbors
// ---------------------------------------------------------------------------
module sle_cell #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX        = 0
) (
  input  logic                           clk,
  input  sle_pkg::sle_cmd_t              cmd,
  input  logic [$clog2(DEPTH+1)-1:0]     pos,
  input  logic [DATA_WIDTH-1:0]          val,
  input  logic [DATA_WIDTH-1:0]          left_entry,
  input  logic [DATA_WIDTH-1:0]          right_entry,
  input  logic                           right_match,
  output logic [DATA_WIDTH-1:0]          entry,
  output logic                           match
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INSERT: begin
        if (MY_IDX > pos) begin
          entry <= left_entry;
        end else if (MY_IDX == pos) begin
          entry <= val;
        end
      end
      CMD_ERASE: begin
        if (MY_IDX >= pos) begin
          entry <= right_entry;
        end
      end
      CMD_MATCH: match <= (entry == val);
      CMD_SCAN:  match <= right_match;
      default: ;
    endcase
  end

endmodule

// ===== src/sle_ctrl.sv =====
// ---------------------------------------------------------------------------
// sle_ctrl
// decodes requests, keeps the element count, drives the cells, runs the scan
// ---------------------------------------------------------------------------
`include "sequence_list_engine_top_assert.svh"

module sle_ctrl #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  sle_pkg::sle_req_t          req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output sle_pkg::sle_rsp_t          rsp,
  input  logic                       head_match,
  output sle_pkg::sle_cmd_t          cmd,
  output logic [$clog2(DEPTH+1)-1:0] pos,
  output logic [DATA_WIDTH-1:0]      val
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  sle_state_t       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic             rsp_valid_next;
  sle_rsp_t         rsp_next;
  logic             rsp_load;
  logic             slot_free;
  logic             accept;
  logic [CMP_W-1:0] pos_wide;
  logic [CMP_W-1:0] cnt_wide;
  logic [63:0]      val_wide;
  logic [31:0]      cnt_ext;
  logic [31:0]      idx_ext;
  sle_status_t      stat;
  logic             hit;

  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign pos_wide  = CMP_W'(req.position);
  assign cnt_wide  = CMP_W'(count);
  // value is taken as an unsigned word, low bits kept
  assign val_wide  = {32'd0, req.value};
  assign val       = val_wide[DATA_WIDTH-1:0];

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    cmd            = CMD_HOLD;
    pos            = '0;
    stat           = STAT_OK;
    hit            = 1'b0;
    rsp_load       = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          unique case (sle_op_t'(req.op))
            OP_PUSH_BACK: begin
              if (count == FULL_CNT) begin
                stat = STAT_FULL;
              end else begin
                cmd        = CMD_INSERT;
                pos        = count;
                count_next = count + 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (count == '0) begin
                stat = STAT_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (count == FULL_CNT) begin
                stat = STAT_FULL;
              end else begin
                cmd        = CMD_INSERT;
                count_next = count + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count == '0) begin
                stat = STAT_EMPTY;
              end else begin
                cmd        = CMD_ERASE;
                count_next = count - 1'b1;
              end
            end
            OP_INSERT_AT: begin
              if (count == FULL_CNT) begin
                stat = STAT_FULL;
              end else if (pos_wide > cnt_wide) begin
                stat = STAT_BADPOS;
              end else begin
                cmd        = CMD_INSERT;
                pos        = pos_wide[CNT_W-1:0];
                count_next = count + 1'b1;
              end
            end
            OP_ERASE_AT: begin
              if (count == '0) begin
                stat = STAT_EMPTY;
              end else if (pos_wide >= cnt_wide) begin
                stat = STAT_BADPOS;
              end else begin
                cmd        = CMD_ERASE;
                pos        = pos_wide[CNT_W-1:0];
                count_next = count - 1'b1;
              end
            end
            OP_FIND: begin
              rsp_load   = 1'b0;
              cmd        = CMD_MATCH;
              idx_next   = '0;
              state_next = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (slot_free) begin
          if (idx == count) begin
            rsp_load   = 1'b1;
            state_next = S_IDLE;
          end else if (head_match) begin
            rsp_load   = 1'b1;
            hit        = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd      = CMD_SCAN;
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end
  end

  assign cnt_ext = 32'(count_next);
  assign idx_ext = hit ? 32'(idx) : 32'd0;

  always_comb begin
    rsp_next.status      = stat;
    rsp_next.found       = hit;
    rsp_next.found_index = idx_ext[3:0];
    rsp_next.count       = cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  `SLE_ASSERT_NEXT(a_quick_op_responds, accept && (req.op != OP_FIND), rsp_valid, "no beat after list op")
  `SLE_ASSERT_NEXT(a_count_only_on_accept, !accept, $stable(count), "count moved without a request")
  `SLE_ASSERT_NOW(a_scan_within_count, state == S_SCAN, idx <= count, "scan ran past the count")
  `SLE_ASSERT_NOW(a_count_bounded, rsp_valid, count <= FULL_CNT, "count above depth")

endmodule

// ===== src/sequence_list_engine_top.sv =====
// ---------------------------------------------------------------------------
// sequence list engine
// fixed-depth ordered list of signed words with insert, erase and find
// ---------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, one entry per cell. On push,
// pop front, insert and erase, every cell from the target index on takes
// a neighbor's entry or the new value in the same clock; pop back moves no
// entry. The response is registered in the cycle after the request beat.
// Find: all cells compare against the value in the first cycle, then the
// match bits walk down the row one position a cycle while the response
// slot is free, and the head bit marks the first match at the running
// index (the scan ends at the element count when absent). A new request
// is taken only when the engine is idle and the response register is
// empty or being drained. Only the low DATA_WIDTH bits of value are stored
// and compared. Entries above the count hold stale data, never reported.
module sequence_list_engine_top #(
  parameter int DEPTH      = sle_pkg::SLE_DEPTH,
  parameter int DATA_WIDTH = sle_pkg::SLE_DATA_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              req_valid,
  output logic              req_ready,
  input  sle_pkg::sle_req_t req,
  // response channel
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output sle_pkg::sle_rsp_t rsp
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // broadcast from control to every cell
  sle_cmd_t              cmd;
  logic [CNT_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] val;

  // cell row contents
  logic [DATA_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]      match;

  sle_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .head_match (match[0]),   // scan looks only at the head cell
    .cmd        (cmd),
    .pos        (pos),
    .val        (val)
  );

  // the cell row: entries move up on insert, down on erase,
  // match bits move down during a scan
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_entry;
    logic [DATA_WIDTH-1:0] right_entry;
    logic                  right_match;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_inner_left
      assign left_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      // nothing beyond the last cell
      assign right_entry = '0;
      assign right_match = 1'b0;
    end else begin : g_inner_right
      assign right_entry = entry[i+1];
      assign right_match = match[i+1];
    end

    sle_cell #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .pos         (pos),
      .val         (val),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .right_match (right_match),
      .entry       (entry[i]),
      .match       (match[i])
    );
  end

endmodule

// ===== tb/sequence_list_engine_top_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sequence list engine testbench
// drives list operations through the request channel, keeps its own copy
// of the list to predict every response beat, and checks each response
// field by field under random idling on both channels
// ---------------------------------------------------------------------------
module sequence_list_engine_top_test;
  import sle_pkg::*;

  localparam int QUIET_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int TAIL_CYCLES = 40;    // longest find plus margin
  localparam logic [2:0] OP_UNUSED = 3'd7;  // opcode with no operation behind it

  // list contents and fill level, one copy per user
  typedef struct {
    logic [SLE_DATA_WIDTH-1:0] slot [SLE_DEPTH];
    int                        fill;
  } word_list_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  sle_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  sle_rsp_t rsp;

  sle_req_t   pending_reqs [$];  // request beats not yet offered
  sle_rsp_t   expected_rsps [$]; // predicted responses, oldest first
  word_list_t shadow_list;       // follows accepted requests
  word_list_t plan_list;         // follows generated requests, steers the stimulus
  int         idle_pct = 0;      // chance per cycle of opening an idle burst
  int         req_gap = 0;
  int         rsp_stall = 0;
  int         quiet_cycles = 0;
  int         mismatches = 0;

  sequence_list_engine_top DUT (
    .clk       (clk),
    .rsp       (rsp),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one request to a list and returns the response it yields
  function automatic sle_rsp_t list_apply(inout word_list_t lst, input sle_req_t r);
    sle_rsp_t o;
    int       k;
    int       pos;
    logic     hit;
    o        = '0;
    o.status = STAT_OK;
    pos      = int'(r.position);
    hit      = 1'b0;
    case (r.op) inside
      OP_PUSH_BACK: begin
        if (lst.fill >= SLE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          lst.slot[lst.fill] = r.value;
          lst.fill++;
        end
      end
      OP_POP_BACK: begin
        if (lst.fill == 0) o.status = STAT_EMPTY;
        else lst.fill--;
      end
      OP_PUSH_FRONT, OP_INSERT_AT: begin
        if (r.op == OP_PUSH_FRONT) pos = 0;
        // full is checked before the position
        if (lst.fill >= SLE_DEPTH) begin
          o.status = STAT_FULL;
        end else if (pos > lst.fill) begin
          o.status = STAT_BADPOS;
        end else begin
          for (k = lst.fill; k > pos; k--) lst.slot[k] = lst.slot[k-1];
          lst.slot[pos] = r.value;
          lst.fill++;
        end
      end
      OP_POP_FRONT, OP_ERASE_AT: begin
        if (r.op == OP_POP_FRONT) pos = 0;
        if (lst.fill == 0) begin
          o.status = STAT_EMPTY;
        end else if (pos >= lst.fill) begin
          o.status = STAT_BADPOS;
        end else begin
          for (k = pos; k + 1 < lst.fill; k++) lst.slot[k] = lst.slot[k+1];
          lst.fill--;
        end
      end
      OP_FIND: begin
        // first match wins
        for (k = 0; k < lst.fill; k++) begin
          if (!hit && lst.slot[k] == r.value) begin
            hit           = 1'b1;
            o.found       = 1'b1;
            o.found_index = 4'(k);
          end
        end
      end
      default: ;  // unused opcode leaves the list alone
    endcase
    o.count = 5'(lst.fill);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: offers pending beats, holds them until taken, and opens
  // random idle bursts between beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap = 0;
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(list_apply(shadow_list, req));
      // a beat that is still waiting stays on the bus untouched
      if (!req_valid || req_ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            req_gap = $urandom_range(9);
            req_valid <= 1'b0;
          end else begin
            req       <= pending_reqs.pop_front();
            req_valid <= 1'b1;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response monitor: checks each accepted beat against the oldest
  // prediction and stalls the response channel in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sle_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response beat with no request outstanding: %h", rsp);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, rsp.found);
            mismatches++;
          end
          if (rsp.found_index !== want.found_index) begin
            $error("found_index mismatch: expected %0d, got %0d",
                   want.found_index, rsp.found_index);
            mismatches++;
          end
          if (rsp.count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, rsp.count);
            mismatches++;
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        rsp_stall = $urandom_range(9);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // watchdog: only counts while work is outstanding
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (!req_valid && pending_reqs.size() == 0 && expected_rsps.size() == 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // queues one request and moves the planning copy along with it
  task automatic queue_req(input logic [2:0] op, input logic [4:0] pos,
                           input logic [31:0] val);
    sle_req_t r;
    r.op       = op;
    r.position = pos;
    r.value    = val;
    pending_reqs.push_back(r);
    void'(list_apply(plan_list, r));
  endtask

  // half random words, half the extremes and small values from 0 to 3 that repeat
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'(($urandom_range(3)));
      default: return $urandom;
    endcase
  endfunction

  // one random request; bias 0 grows the list, 1 shrinks it, 2 keeps it level
  task automatic queue_random(input int bias);
    int          roll;
    int          grow_pct;
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;
    grow_pct = (bias == 0) ? 65 : (bias == 1) ? 22 : 40;
    roll     = $urandom_range(99);
    val      = pick_word();
    pos      = 5'($urandom_range(plan_list.fill));
    if ($urandom_range(9) == 0) begin
      // noise: any opcode, any position, including the unused opcode
      op  = 3'($urandom_range(7));
      pos = 5'($urandom_range(31));
    end else if (roll < 25) begin
      op = OP_FIND;
      if (plan_list.fill > 0 && $urandom_range(9) < 6)
        val = plan_list.slot[$urandom_range(plan_list.fill - 1)];
    end else if (roll < 25 + grow_pct) begin
      case ($urandom_range(2))
        0: op = OP_PUSH_BACK;
        1: op = OP_PUSH_FRONT;
        default: op = OP_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0: op = OP_POP_BACK;
        1: op = OP_POP_FRONT;
        default: begin
          op = OP_ERASE_AT;
          if (plan_list.fill > 0) pos = 5'($urandom_range(plan_list.fill - 1));
        end
      endcase
    end
    queue_req(op, pos, val);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: reset, a directed pass over the corner cases, then random
  // phases with changing idle rates and list pressure, the last one calm
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    int n;
    shadow_list.fill = 0;
    plan_list.fill   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // operations on an empty list
    queue_req(OP_POP_BACK,   5'd0,  32'd0);
    queue_req(OP_POP_FRONT,  5'd0,  32'd0);
    queue_req(OP_ERASE_AT,   5'd0,  32'd0);
    queue_req(OP_FIND,       5'd0,  32'd5);
    queue_req(OP_UNUSED,     5'd31, 32'hffff_ffff);
    queue_req(OP_INSERT_AT,  5'd1,  32'd9);          // past the count
    // build a small list from the extremes
    queue_req(OP_INSERT_AT,  5'd0,  32'h8000_0000);
    queue_req(OP_PUSH_BACK,  5'd0,  32'h7fff_ffff);
    queue_req(OP_PUSH_FRONT, 5'd0,  32'hffff_ffff);
    queue_req(OP_PUSH_BACK,  5'd0,  32'd0);
    queue_req(OP_INSERT_AT,  5'd4,  32'hffff_ffff);  // position equal to count appends
    queue_req(OP_FIND,       5'd0,  32'hffff_ffff);  // duplicate, first index wins
    queue_req(OP_FIND,       5'd0,  32'd0);
    queue_req(OP_FIND,       5'd0,  32'h7fff_ffff);
    queue_req(OP_FIND,       5'd0,  32'd12345);      // absent
    queue_req(OP_ERASE_AT,   5'd31, 32'd0);
    queue_req(OP_ERASE_AT,   5'd5,  32'd0);          // position equal to count
    queue_req(OP_INSERT_AT,  5'd31, 32'd1);
    queue_req(OP_INSERT_AT,  5'd2,  32'd77);
    queue_req(OP_ERASE_AT,   5'd1,  32'd0);
    queue_req(OP_POP_FRONT,  5'd0,  32'd0);
    queue_req(OP_POP_BACK,   5'd0,  32'd0);
    queue_req(OP_FIND,       5'd0,  32'd77);

    // random phases; growing phases run into the full list
    for (phase = 0; phase < 8; phase++) begin
      while (pending_reqs.size() > 0) @(posedge clk);
      case (phase % 4)
        0: idle_pct = 8;
        1: idle_pct = 0;
        2: idle_pct = 30;
        default: idle_pct = 15;
      endcase
      if (phase == 7) idle_pct = 0;
      for (n = 0; n < 210; n++) queue_random(phase % 3);
    end

    while (pending_reqs.size() > 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sle_pkg.sv
src/sle_cell.sv
src/sle_ctrl.sv
src/sequence_list_engine_top.sv
tb/sequence_list_engine_top_test.sv
